### hw/rtl/htbl_pkg.sv
package htbl_pkg;

   localparam int NUM_BUCKETS    = 1024;
   localparam int IDX_W          = $clog2(NUM_BUCKETS);
   localparam int MAX_ADDR_BYTES = 16;
   localparam int LEN_W          = 5;
   localparam int OUT_IDX_W      = 10;
   localparam int DIV_STEPS      = 64;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   localparam logic [31:0] HASH_BASIS = 32'd2166136261;
   localparam logic [31:0] HASH_PRIME = 32'd16777619;
   localparam logic [31:0] MS_PER_S   = 32'd1000;
   // ceil(2^38 / 1000): x / 1000 == (x * RECIP_1000) >> 38 for any 32-bit x
   localparam logic [31:0] RECIP_1000 = 32'd274877907;

   // Configuration register indexes
   localparam logic CSR_RATE  = 1'b0;
   localparam logic CSR_BURST = 1'b1;

   typedef enum logic [1:0] {
      F_IDLE,
      F_HASH,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_CALC,
      B_SPLIT,
      B_MUL,
      B_ADD,
      B_SAT,
      B_START2,
      B_WAIT2,
      B_DECIDE
   } back_state_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [31:0]      now;
   } entry_type;

   typedef struct packed {
      logic        seen;
      logic [31:0] tokens;
      logic [31:0] refill;
   } bucket_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

endpackage

### hw/rtl/htbl_front.sv
module htbl_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [63:0]              req_addr_low,
   input  logic [63:0]              req_addr_high,
   input  logic [4:0]               req_addr_len,
   input  logic [31:0]              req_now_ms,
   output logic                     push_valid,
   input  logic                     push_ready,
   output htbl_pkg::entry_type      push_data
);

   htbl_pkg::front_state_type state_ff, state_in;
   logic [127:0]              bytes_ff;
   logic [4:0]                left_ff;
   logic [31:0]               hash_ff;
   logic [31:0]               now_ff;
   logic [31:0]               hash_x;
   logic [63:0]               hash_prod;
   logic [4:0]                len_clamped;
   logic                      accept;

   assign accept      = req_valid && req_ready;
   assign len_clamped = (req_addr_len > 5'(htbl_pkg::MAX_ADDR_BYTES))
                        ? 5'(htbl_pkg::MAX_ADDR_BYTES) : req_addr_len;
   assign hash_x      = hash_ff ^ {24'd0, bytes_ff[7:0]};
   assign hash_prod   = {32'd0, hash_x} * {32'd0, htbl_pkg::HASH_PRIME};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         htbl_pkg::F_IDLE: if (accept) state_in = htbl_pkg::F_HASH;
         htbl_pkg::F_HASH: if (left_ff == 5'd0) state_in = htbl_pkg::F_PUSH;
         htbl_pkg::F_PUSH: if (push_ready) state_in = htbl_pkg::F_IDLE;
         default:          state_in = htbl_pkg::F_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready  = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         htbl_pkg::F_IDLE: req_ready  = enable;
         htbl_pkg::F_PUSH: push_valid = 1'b1;
         default: begin
            req_ready  = 1'b0;
            push_valid = 1'b0;
         end
      endcase
   end

   assign push_data.idx = hash_ff[htbl_pkg::IDX_W-1:0];
   assign push_data.now = now_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= htbl_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hash one byte a cycle, byte 0 first
   always_ff @(posedge clock) begin
      if (accept) begin
         bytes_ff <= {req_addr_high, req_addr_low};
         left_ff  <= len_clamped;
         hash_ff  <= htbl_pkg::HASH_BASIS;
         now_ff   <= req_now_ms;
      end else if (state_ff == htbl_pkg::F_HASH && left_ff != 5'd0) begin
         bytes_ff <= {8'd0, bytes_ff[127:8]};
         left_ff  <= left_ff - 5'd1;
         hash_ff  <= hash_prod[31:0];
      end
   end

endmodule

### hw/rtl/htbl_queue.sv
module htbl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  htbl_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop,
   output htbl_pkg::entry_type pop_data
);

   htbl_pkg::entry_type entries_ff [2];
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          count_ff;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Track fill level and pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (do_push && !do_pop)      count_ff <= count_ff + 2'd1;
         else if (do_pop && !do_push) count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### hw/rtl/htbl_div.sv
module htbl_div (
   input  logic                  clock,
   input  logic                  reset,
   input  htbl_pkg::div_req_type div_req,
   output logic                  div_done,
   output logic [63:0]           div_quo
);

   logic [63:0]                    quo_ff;
   logic [31:0]                    rem_ff;
   logic [htbl_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [31:0]                    divisor_ff;
   logic                           busy_ff;
   logic                           done_ff;
   logic [32:0]                    trial;
   logic [32:0]                    diff;
   logic                           fits;

   assign trial    = {rem_ff, quo_ff[63]};
   assign diff     = trial - {1'b0, divisor_ff};
   assign fits     = (trial >= {1'b0, divisor_ff});
   assign div_done = done_ff;
   assign div_quo  = quo_ff;

   // Sequence the steps, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == htbl_pkg::DIV_CNT_W'(htbl_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Restoring shift and subtract
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff     <= div_req.dividend;
         rem_ff     <= '0;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[62:0], fits};
         rem_ff <= fits ? diff[31:0] : trial[31:0];
      end
   end

endmodule

### hw/rtl/htbl_back.sv
module htbl_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [31:0]                  rate,
   input  logic [31:0]                  burst,
   input  logic                         q_valid,
   input  htbl_pkg::entry_type          q_data,
   output logic                         q_pop,
   output logic                         clear_done,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_allowed,
   output logic [htbl_pkg::OUT_IDX_W-1:0] rsp_bucket_index,
   output logic [31:0]                  rsp_tokens_left
);

   htbl_pkg::back_state_type state_ff, state_in;
   htbl_pkg::bucket_type     mem [htbl_pkg::NUM_BUCKETS];
   htbl_pkg::bucket_type     rd_data_ff;
   htbl_pkg::bucket_type     wr_data;
   htbl_pkg::div_req_type    div_req;
   logic [htbl_pkg::IDX_W-1:0] clr_cnt_ff;
   logic [htbl_pkg::IDX_W-1:0] idx_ff;
   logic [htbl_pkg::IDX_W-1:0] wr_addr;
   logic [31:0]              now_ff;
   logic [31:0]              tokens_ff;
   logic [31:0]              refill_ff;
   logic [63:0]              prod_ff;
   logic [63:0]              add_ff;
   logic [31:0]              q1_ff;
   logic [31:0]              q2_ff;
   logic [9:0]               r1_ff;
   logic [9:0]               r2_ff;
   logic [19:0]              rr_ff;
   logic                     dis_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_allowed_ff;
   logic [htbl_pkg::OUT_IDX_W-1:0] rsp_idx_ff;
   logic [31:0]              rsp_tokens_ff;
   logic                     div_done;
   logic [63:0]              div_quo;
   logic                     disabled;
   logic                     out_free;
   logic                     mem_we;
   logic                     finish;
   logic [31:0]              elapsed;
   logic [63:0]              sum;
   logic                     clr_last;
   logic [63:0]              q1_prod;
   logic [63:0]              q2_prod;
   logic [31:0]              r1_full;
   logic [31:0]              r2_full;
   logic [41:0]              r1q2;
   logic [19:0]              rr;
   logic [63:0]              rr_prod;
   logic [63:0]              add_x1000;

   assign disabled  = (rate == 32'd0) || (burst == 32'd0);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign elapsed   = now_ff - refill_ff;
   assign sum       = {32'd0, tokens_ff} + add_ff;
   assign clr_last  = (clr_cnt_ff == {htbl_pkg::IDX_W{1'b1}});

   // Split elapsed*rate/1000 into pieces that each fit a 32 by 32 multiply:
   // elapsed = q1*1000 + r1, rate = q2*1000 + r2,
   // add = q1*rate + r1*q2 + (r1*r2)/1000
   assign q1_prod   = {32'd0, elapsed} * {32'd0, htbl_pkg::RECIP_1000};
   assign q2_prod   = {32'd0, rate} * {32'd0, htbl_pkg::RECIP_1000};
   assign r1_full   = elapsed - q1_ff * htbl_pkg::MS_PER_S;
   assign r2_full   = rate - q2_ff * htbl_pkg::MS_PER_S;
   assign r1q2      = {32'd0, r1_ff} * {10'd0, q2_ff};
   assign rr        = {10'd0, r1_ff} * {10'd0, r2_ff};
   assign rr_prod   = {44'd0, rr_ff} * {32'd0, htbl_pkg::RECIP_1000};
   assign add_x1000 = (add_ff << 10) - (add_ff << 4) - (add_ff << 3);

   htbl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         htbl_pkg::B_CLEAR:  if (clr_last) state_in = htbl_pkg::B_IDLE;
         htbl_pkg::B_IDLE:
            if (q_valid) state_in = disabled ? htbl_pkg::B_DECIDE : htbl_pkg::B_READ;
         htbl_pkg::B_READ:   state_in = htbl_pkg::B_CALC;
         htbl_pkg::B_CALC:
            state_in = (elapsed == 32'd0) ? htbl_pkg::B_DECIDE : htbl_pkg::B_SPLIT;
         htbl_pkg::B_SPLIT:  state_in = htbl_pkg::B_MUL;
         htbl_pkg::B_MUL:    state_in = htbl_pkg::B_ADD;
         htbl_pkg::B_ADD:    state_in = htbl_pkg::B_SAT;
         htbl_pkg::B_SAT:
            state_in = (add_ff == 64'd0) ? htbl_pkg::B_DECIDE : htbl_pkg::B_START2;
         htbl_pkg::B_START2: state_in = htbl_pkg::B_WAIT2;
         htbl_pkg::B_WAIT2:  if (div_done) state_in = htbl_pkg::B_DECIDE;
         htbl_pkg::B_DECIDE: if (out_free) state_in = htbl_pkg::B_IDLE;
         default:            state_in = htbl_pkg::B_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      q_pop            = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = add_x1000;
      div_req.divisor  = rate;
      mem_we           = 1'b0;
      finish           = 1'b0;
      wr_addr          = idx_ff;
      wr_data.seen     = 1'b1;
      wr_data.tokens   = tokens_ff - 32'd1;
      wr_data.refill   = refill_ff;
      case (state_ff)
         htbl_pkg::B_CLEAR: begin
            mem_we       = 1'b1;
            wr_addr      = clr_cnt_ff;
            wr_data.seen = 1'b0;
         end
         htbl_pkg::B_IDLE:   q_pop = q_valid;
         htbl_pkg::B_START2: div_req.start = 1'b1;
         htbl_pkg::B_DECIDE: begin
            finish = out_free;
            mem_we = out_free && !dis_ff && (tokens_ff != 32'd0);
         end
         default: q_pop = 1'b0;
      endcase
   end

   assign clear_done       = (state_ff != htbl_pkg::B_CLEAR);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_allowed      = rsp_allowed_ff;
   assign rsp_bucket_index = rsp_idx_ff;
   assign rsp_tokens_left  = rsp_tokens_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= htbl_pkg::B_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == htbl_pkg::B_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (finish)         rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Bucket store
   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[q_data.idx];
   end

   // Refill, saturate and consume
   always_ff @(posedge clock) begin
      case (state_ff)
         htbl_pkg::B_IDLE: begin
            idx_ff <= q_data.idx;
            now_ff <= q_data.now;
            dis_ff <= disabled;
         end
         htbl_pkg::B_READ: begin
            tokens_ff <= rd_data_ff.seen ? rd_data_ff.tokens : burst;
            refill_ff <= rd_data_ff.seen ? rd_data_ff.refill : now_ff;
         end
         htbl_pkg::B_CALC: begin
            q1_ff <= {6'd0, q1_prod[63:38]};
            q2_ff <= {6'd0, q2_prod[63:38]};
         end
         htbl_pkg::B_SPLIT: begin
            r1_ff   <= r1_full[9:0];
            r2_ff   <= r2_full[9:0];
            prod_ff <= {32'd0, q1_ff} * {32'd0, rate};
         end
         htbl_pkg::B_MUL: begin
            prod_ff <= prod_ff + {22'd0, r1q2};
            rr_ff   <= rr;
         end
         htbl_pkg::B_ADD: add_ff <= prod_ff + {38'd0, rr_prod[63:38]};
         htbl_pkg::B_SAT: begin
            if (add_ff != 64'd0)
               tokens_ff <= (sum > {32'd0, burst}) ? burst : sum[31:0];
         end
         htbl_pkg::B_WAIT2: if (div_done) refill_ff <= refill_ff + div_quo[31:0];
         htbl_pkg::B_DECIDE: begin
            if (finish) begin
               if (dis_ff) begin
                  rsp_allowed_ff <= 1'b1;
                  rsp_idx_ff     <= '0;
                  rsp_tokens_ff  <= 32'd0;
               end else begin
                  rsp_allowed_ff <= (tokens_ff != 32'd0);
                  rsp_idx_ff     <= htbl_pkg::OUT_IDX_W'(idx_ff);
                  rsp_tokens_ff  <= (tokens_ff != 32'd0) ? tokens_ff - 32'd1 : 32'd0;
               end
            end
         end
         default: add_ff <= add_ff;
      endcase
   end

endmodule

### hw/rtl/hashed_token_bucket_limiter.sv
// Hashed token bucket rate limiter.
// Request channel (req_*): one transaction per client request with the
// address bytes, their count (clamped to 16) and the millisecond time.
// Response channel (rsp_*): one transaction per request, in order, with the
// allow decision, the bucket index and the tokens left.
// Config channel (csr_*): index 0 writes the refill rate, index 1 the burst
// limit; write only while no request is in flight. Either at zero allows all.
// Sequence: the front hashes one byte a cycle. The back decides at once when
// limiting is disabled, after a read and time check when no time has elapsed,
// after split, multiply, add and saturate when no token is added, and on a
// refill after the one-bit-per-cycle 64-step divider advances the refill time.
// A two-entry queue lets the front hash the next address while the back works.
// Reset: rate and burst clear, and a clearing pass marks all 1024 buckets
// unused; req_ready stays low until it ends.
// Stall: the response holds in its output register while rsp_ready is low;
// the back then waits, and the front keeps accepting until the queue fills.
module hashed_token_bucket_limiter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_addr_low,
   input  logic [63:0] req_addr_high,
   input  logic [4:0]  req_addr_len,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_allowed,
   output logic [9:0]  rsp_bucket_index,
   output logic [31:0] rsp_tokens_left,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   logic [31:0]         rate_ff;
   logic [31:0]         burst_ff;
   logic                clear_done;
   logic                push_valid;
   logic                push_ready;
   htbl_pkg::entry_type push_data;
   logic                q_valid;
   logic                q_pop;
   htbl_pkg::entry_type q_data;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= 32'd0;
         burst_ff <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            htbl_pkg::CSR_RATE:  rate_ff  <= csr_data;
            htbl_pkg::CSR_BURST: burst_ff <= csr_data;
            default:             rate_ff  <= rate_ff;
         endcase
      end
   end

   htbl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .enable        (clear_done),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_addr_low  (req_addr_low),
      .req_addr_high (req_addr_high),
      .req_addr_len  (req_addr_len),
      .req_now_ms    (req_now_ms),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   htbl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   htbl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .rate             (rate_ff),
      .burst            (burst_ff),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .clear_done       (clear_done),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_allowed      (rsp_allowed),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_tokens_left  (rsp_tokens_left)
   );

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      !clear_done |-> !req_ready)
      else $error("request accepted during clearing pass");

   a_denied_has_no_tokens: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_allowed) |-> (rsp_tokens_left == 32'd0))
      else $error("denied response reports tokens");

   a_disabled_allows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rate_ff == 32'd0 || burst_ff == 32'd0)) |->
      (rsp_allowed && rsp_bucket_index == 10'd0 && rsp_tokens_left == 32'd0))
      else $error("disabled limiter response wrong");

endmodule

### verif/tb_hashed_token_bucket_limiter.sv
`timescale 1ns / 100ps

module tb_hashed_token_bucket_limiter;

   localparam int STALL_LIMIT = 6000;
   localparam int HOLD_CYCLES = 700;
   localparam int POOL_SIZE   = 8;

   // Tracks bucket state and the queue of expected decisions
   class limiter_scoreboard;
      typedef struct {
         bit        allowed;
         bit [9:0]  bucket;
         bit [31:0] tokens;
      } decision_type;

      bit [31:0]    rate;
      bit [31:0]    burst;
      bit [31:0]    bucket_tokens [htbl_pkg::NUM_BUCKETS];
      bit [31:0]    bucket_stamp [htbl_pkg::NUM_BUCKETS];
      bit           bucket_used [htbl_pkg::NUM_BUCKETS];
      decision_type decisions [$];
      int           errors;

      function new();
         rate = '0;
         burst = '0;
         errors = 0;
         foreach (bucket_used[i]) bucket_used[i] = 1'b0;
      endfunction

      function void set_csr(bit idx, bit [31:0] data);
         if (idx == htbl_pkg::CSR_RATE) rate = data;
         else burst = data;
      endfunction

      function int pending();
         return decisions.size();
      endfunction

      // Compute the decision for an accepted request and update the bucket
      function void note_request(bit [63:0] lo, bit [63:0] hi, bit [4:0] len,
                                 bit [31:0] now);
         decision_type d;
         bit [31:0] h;
         bit [31:0] cnt;
         bit [7:0]  b;
         bit [9:0]  idx;
         bit [31:0] tok;
         bit [31:0] stamp;
         bit [31:0] elapsed;
         bit [63:0] add;
         bit [63:0] ntok;
         if (rate == 0 || burst == 0) begin
            d = '{1'b1, 10'd0, 32'd0};
            decisions.push_back(d);
            return;
         end
         cnt = (len > htbl_pkg::MAX_ADDR_BYTES) ? htbl_pkg::MAX_ADDR_BYTES : len;
         h = htbl_pkg::HASH_BASIS;
         for (int i = 0; i < cnt; i++) begin
            b = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
            h = (h ^ {24'd0, b}) * htbl_pkg::HASH_PRIME;
         end
         idx = h[9:0];
         if (bucket_used[idx]) begin
            tok = bucket_tokens[idx];
            stamp = bucket_stamp[idx];
         end else begin
            tok = burst;
            stamp = now;
         end
         ntok = {32'd0, tok};
         elapsed = now - stamp;
         if (elapsed != 0) begin
            add = ({32'd0, elapsed} * {32'd0, rate}) / 64'd1000;
            if (add != 0) begin
               ntok = ntok + add;
               if (ntok > {32'd0, burst}) ntok = {32'd0, burst};
               stamp = stamp + 32'((add * 64'd1000) / {32'd0, rate});
            end
         end
         if (ntok == 0) begin
            d = '{1'b0, idx, 32'd0};
         end else begin
            ntok = ntok - 1;
            bucket_tokens[idx] = ntok[31:0];
            bucket_stamp[idx] = stamp;
            bucket_used[idx] = 1'b1;
            d = '{1'b1, idx, ntok[31:0]};
         end
         decisions.push_back(d);
      endfunction

      // Compare one response transaction with the oldest expected decision
      function void check_result(bit allowed, bit [9:0] bucket, bit [31:0] tokens);
         decision_type d;
         if (decisions.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected response allowed=%0d bucket=%0d tokens=%0d",
                        allowed, bucket, tokens);
            return;
         end
         d = decisions.pop_front();
         if (d.allowed !== allowed || d.bucket !== bucket || d.tokens !== tokens) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: expected allowed=%0d bucket=%0d tokens=%0d, got %0d %0d %0d",
                        d.allowed, d.bucket, d.tokens, allowed, bucket, tokens);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_addr_low;
   logic [63:0] req_addr_high;
   logic [4:0]  req_addr_len;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_allowed;
   logic [9:0]  rsp_bucket_index;
   logic [31:0] rsp_tokens_left;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_data;

   limiter_scoreboard sb;
   int hold_count;
   int idle_cycles;
   int burst_left;
   bit [31:0] now;
   bit [63:0] pool_low [POOL_SIZE];
   bit [63:0] pool_high [POOL_SIZE];
   bit [4:0]  pool_len [POOL_SIZE];

   hashed_token_bucket_limiter u_top (.*);

   // Clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Observe accepted transactions on the request and response channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_addr_low, req_addr_high, req_addr_len, req_now_ms);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_allowed, rsp_bucket_index, rsp_tokens_left);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Receiver: hold off on request, else stall on a shifting pattern
   always @(posedge clock) begin
      if (hold_count > 0) begin
         rsp_ready <= 1'b0;
         hold_count <= hold_count - 1;
      end else begin
         case ((now >> 9) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   task automatic write_csr(bit idx, bit [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_csr(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait for every outstanding decision, then let the block settle
   task automatic drain();
      while (sb.pending() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // Offer one request; drop valid between bursts
   task automatic send_request(bit [63:0] lo, bit [63:0] hi, bit [4:0] len,
                               bit [31:0] t);
      req_valid <= 1'b1;
      req_addr_low <= lo;
      req_addr_high <= hi;
      req_addr_len <= len;
      req_now_ms <= t;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic fill_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_low[i] = {$urandom, $urandom};
         pool_high[i] = {$urandom, $urandom};
         pool_len[i] = (i == 0) ? 5'd4 : (i == 1) ? 5'd16 : 5'($urandom_range(0, 31));
      end
   endtask

   // Random phase: mostly repeat clients with small time steps
   task automatic random_phase(int count, bit [31:0] step_max);
      int sel;
      int p;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 70) now = now + $urandom_range(0, 2);
         else if (sel < 92) now = now + $urandom_range(0, step_max);
         else if (sel < 96) now = $urandom;
         p = $urandom_range(0, POOL_SIZE - 1);
         if ($urandom_range(0, 19) == 0)
            send_request({$urandom, $urandom}, {$urandom, $urandom},
                         5'($urandom_range(0, 31)), now);
         else
            send_request(pool_low[p], pool_high[p], pool_len[p], now);
      end
      stop_sending();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_addr_low = '0;
      req_addr_high = '0;
      req_addr_len = '0;
      req_now_ms = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = htbl_pkg::CSR_RATE;
      csr_data = '0;
      hold_count = 0;
      idle_cycles = 0;
      burst_left = 4;
      now = 32'd100;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Limiting disabled after reset
      send_request('0, '0, 5'd0, 32'd0);
      send_request('1, '1, 5'd31, 32'hFFFF_FFFF);
      stop_sending();
      drain();

      // Drain one bucket, then refill by one token
      write_csr(htbl_pkg::CSR_RATE, 32'd1000);
      write_csr(htbl_pkg::CSR_BURST, 32'd3);
      repeat (5) send_request(64'h0100_00C0_A8, '0, 5'd4, 32'd5000);
      send_request(64'h0100_00C0_A8, '0, 5'd4, 32'd5001);
      send_request(64'h0100_00C0_A8, '0, 5'd4, 32'd5001);
      // Empty address, full and clamped lengths, all-ones fields
      send_request('1, '1, 5'd0, 32'd7);
      send_request('1, '1, 5'd16, 32'hFFFF_FFFF);
      send_request('1, '1, 5'd17, 32'hFFFF_FFFF);
      send_request('1, '1, 5'd31, 32'd2);
      send_request(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd16, 32'd9);
      send_request(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd8, 32'd9);
      stop_sending();
      drain();

      // Lower the burst below a stored count, then refill past it
      write_csr(htbl_pkg::CSR_BURST, 32'd1);
      send_request('1, '1, 5'd16, 32'hFFFF_FFFF);
      send_request('1, '1, 5'd16, 32'd5000);
      send_request('1, '1, 5'd16, 32'd5000);
      stop_sending();
      drain();

      // Random phases over a range of settings
      fill_pool();
      write_csr(htbl_pkg::CSR_RATE, 32'd1000);
      write_csr(htbl_pkg::CSR_BURST, 32'd4);
      fork
         random_phase(190, 32'd3000);
         begin
            repeat (300) @(posedge clock);
            hold_count = HOLD_CYCLES;
         end
      join
      drain();

      write_csr(htbl_pkg::CSR_RATE, 32'd50);
      write_csr(htbl_pkg::CSR_BURST, 32'd3);
      random_phase(190, 32'd60);
      drain();

      write_csr(htbl_pkg::CSR_RATE, 32'd1);
      write_csr(htbl_pkg::CSR_BURST, 32'd2);
      random_phase(190, 32'd2500);
      drain();

      fill_pool();
      write_csr(htbl_pkg::CSR_RATE, 32'hFFFF_FFFF);
      write_csr(htbl_pkg::CSR_BURST, 32'hFFFF_FFFF);
      random_phase(190, 32'd10);
      drain();

      write_csr(htbl_pkg::CSR_RATE, 32'd250);
      write_csr(htbl_pkg::CSR_BURST, 32'd1);
      random_phase(190, 32'd10);
      drain();

      write_csr(htbl_pkg::CSR_RATE, 32'd0);
      write_csr(htbl_pkg::CSR_BURST, 32'd5);
      random_phase(60, 32'd100);
      drain();

      write_csr(htbl_pkg::CSR_RATE, 32'd5);
      write_csr(htbl_pkg::CSR_BURST, 32'd0);
      random_phase(60, 32'd100);
      drain();

      fill_pool();
      write_csr(htbl_pkg::CSR_RATE, 32'd2000);
      write_csr(htbl_pkg::CSR_BURST, 32'd20);
      random_phase(190, 32'd4);
      drain();

      write_csr(htbl_pkg::CSR_RATE, 32'd123457);
      write_csr(htbl_pkg::CSR_BURST, 32'd7);
      random_phase(190, 32'd3);
      drain();

      write_csr(htbl_pkg::CSR_RATE, 32'd3);
      write_csr(htbl_pkg::CSR_BURST, 32'h8000_0001);
      random_phase(190, 32'd900);
      drain();

      fill_pool();
      write_csr(htbl_pkg::CSR_RATE, 32'd1000);
      write_csr(htbl_pkg::CSR_BURST, 32'd2);
      random_phase(190, 32'd1500);
      drain();

      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
